[sv/scrs_pkg.sv]
// Package: shared types and constants for the secant cubic root solver.
`default_nettype none
package scrs_pkg;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int LIMIT_W         = 8;
	localparam int TOL_W           = 31;
	localparam int STATUS_W        = 2;
	localparam int CFG_ADDR_W      = 1;
	localparam int CFG_DATA_W      = 31;
	localparam logic [CFG_ADDR_W-1:0] REG_ITERATION_LIMIT = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE       = 1'd1;
	localparam logic [LIMIT_W-1:0]    LIMIT_RESET         = 8'd20;
	localparam logic [TOL_W-1:0]      TOL_RESET           = 31'd7;

	typedef enum logic [STATUS_W-1:0] {
		ST_CONVERGED = 2'd0,
		ST_DIV_ERROR = 2'd1,
		ST_TOO_CLOSE = 2'd2,
		ST_NO_CONV   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_F_SQ, S_F_CUBE, S_F_DONE, S_CHECK0, S_LOOP,
		S_NUM_A, S_NUM_B, S_NUM_C, S_DIV_INIT, S_DIV, S_DIV_DONE, S_CHECK2, S_DONE
	} state_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SQ, OP_CUBE, OP_FIN, OP_NUM_A, OP_NUM_B, OP_NUM_C,
		OP_DIV_START, OP_DIV_STEP, OP_DIV_END, OP_ADVANCE
	} op_t;

	// which value feeds the cubic evaluator
	typedef enum logic [1:0] {
		SEL_X0, SEL_X1, SEL_X2
	} fsel_t;

	typedef struct packed {
		op_t   op;
		fsel_t fsel;
	} scrs_cmd_t;

	typedef struct packed {
		logic f_equal;    // f0 == f1
		logic too_close;  // |f1-f0| < tol
		logic den_zero;   // f1 == f0
		logic conv;       // |f2| <= tol
		logic div_last;   // final quotient bit this step
	} scrs_stat_t;
endpackage
`default_nettype wire

[sv/scrs_ctrl.sv]
// Controller: sequences cubic evaluations, secant division and result reporting.
`default_nettype none
module scrs_ctrl
	import scrs_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire [LIMIT_W-1:0]    limit,
	input  wire scrs_stat_t      stat,
	output logic                 busy,
	output logic                 done,
	output scrs_cmd_t            cmd,
	output status_t              status,
	output logic [LIMIT_W-1:0]   iterations
);
	state_t            state_q, state_nx;
	fsel_t             fsel_q, fsel_nx;
	logic [LIMIT_W-1:0] itr_q, itr_nx;
	status_t           st_q, st_nx;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fsel_q  <= SEL_X0;
			itr_q   <= '0;
			st_q    <= ST_NO_CONV;
		end else begin
			state_q <= state_nx;
			fsel_q  <= fsel_nx;
			itr_q   <= itr_nx;
			st_q    <= st_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		fsel_nx  = fsel_q;
		itr_nx   = itr_q;
		st_nx    = st_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nx = S_LOAD;
					itr_nx   = '0;
				end
			end
			S_LOAD: begin
				fsel_nx  = SEL_X0;
				state_nx = S_F_SQ;
			end
			S_F_SQ:   state_nx = S_F_CUBE;
			S_F_CUBE: state_nx = S_F_DONE;
			S_F_DONE: begin
				if (fsel_q == SEL_X0) begin
					fsel_nx  = SEL_X1;
					state_nx = S_F_SQ;
				end else if (fsel_q == SEL_X1) begin
					state_nx = S_CHECK0;
				end else begin
					state_nx = S_CHECK2;
				end
			end
			S_CHECK0: begin
				if (stat.f_equal) begin
					st_nx    = ST_DIV_ERROR;
					state_nx = S_DONE;
				end else begin
					state_nx = S_LOOP;
				end
			end
			S_LOOP: begin
				if (itr_q == limit) begin
					st_nx    = ST_NO_CONV;
					state_nx = S_DONE;
				end else if (stat.too_close) begin
					st_nx    = ST_TOO_CLOSE;
					state_nx = S_DONE;
				end else if (stat.den_zero) begin
					st_nx    = ST_DIV_ERROR;
					state_nx = S_DONE;
				end else begin
					state_nx = S_NUM_A;
				end
			end
			S_NUM_A:    state_nx = S_NUM_B;
			S_NUM_B:    state_nx = S_NUM_C;
			S_NUM_C:    state_nx = S_DIV_INIT;
			S_DIV_INIT: state_nx = S_DIV;
			S_DIV: begin
				if (stat.div_last) state_nx = S_DIV_DONE;
			end
			S_DIV_DONE: begin
				fsel_nx  = SEL_X2;
				state_nx = S_F_SQ;
			end
			S_CHECK2: begin
				itr_nx = itr_q + LIMIT_W'(1);
				if (stat.conv) begin
					st_nx    = ST_CONVERGED;
					state_nx = S_DONE;
				end else begin
					state_nx = S_LOOP;
				end
			end
			S_DONE:  state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op     = OP_NONE;
		cmd.fsel   = fsel_q;
		busy       = (state_q != S_IDLE);
		done       = (state_q == S_DONE);
		status     = st_q;
		iterations = itr_q;
		case (state_q)
			S_IDLE:     cmd.op = start ? OP_LOAD : OP_NONE;
			S_F_SQ:     cmd.op = OP_SQ;
			S_F_CUBE:   cmd.op = OP_CUBE;
			S_F_DONE:   cmd.op = OP_FIN;
			S_NUM_A:    cmd.op = OP_NUM_A;
			S_NUM_B:    cmd.op = OP_NUM_B;
			S_NUM_C:    cmd.op = OP_NUM_C;
			S_DIV_INIT: cmd.op = OP_DIV_START;
			S_DIV:      cmd.op = OP_DIV_STEP;
			S_DIV_DONE: cmd.op = OP_DIV_END;
			S_CHECK2:   cmd.op = stat.conv ? OP_NONE : OP_ADVANCE;
			default:    cmd.op = OP_NONE;
		endcase
	end
endmodule
`default_nettype wire

[sv/scrs_dp.sv]
// Datapath: estimates, cubic evaluation, secant numerator and restoring divider.
`default_nettype none
module scrs_dp
	import scrs_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire scrs_cmd_t               cmd,
	input  wire signed [VALUE_WIDTH-1:0] x0_in,
	input  wire signed [VALUE_WIDTH-1:0] x1_in,
	input  wire [TOL_W-1:0]              tol,
	input  wire status_t                 status,
	output scrs_stat_t                   stat,
	output logic signed [VALUE_WIDTH-1:0] root
);
	localparam int W   = VALUE_WIDTH;
	localparam int PW  = 2 * W;
	localparam int NW  = 2 * W + 1;
	localparam int CW  = $clog2(NW + 1);
	localparam int TW  = (TOL_W > W + 1) ? TOL_W : W + 1;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W+5:0] ONE  = (W+6)'(1) <<< FRAC_BITS;

	logic signed [W-1:0]  x0_q, x1_q, x2_q, f0_q, f1_q, f2_q;
	logic signed [PW-1:0] prod_q;
	logic signed [NW-1:0] num_q;
	logic [NW-1:0]        nm_q, q_q;
	logic [W:0]           rem_q, d_q;
	logic                 neg_q;
	logic [CW-1:0]        cnt_q;

	logic signed [W-1:0]  xsel, ma, mb;
	logic signed [PW-1:0] pr;
	logic signed [W-1:0]  qm;
	logic signed [W+5:0]  fsum;
	logic signed [W-1:0]  fsat;
	logic signed [W:0]    den;
	logic [W:0]           dmag;
	logic [W+1:0]         rtry;

	// fixed-point product of the registered result: truncate toward zero, saturate
	function automatic logic signed [W-1:0] qsat(input logic signed [PW-1:0] p);
		logic [PW-1:0]        mag;
		logic [PW-1:0]        sh;
		logic                 n;
		n   = p[PW-1];
		mag = n ? PW'(-p) : p;
		sh  = mag >> FRAC_BITS;
		if (n) begin
			if (sh > PW'({1'b1, {(W-1){1'b0}}})) qsat = MINV;
			else qsat = W'(-sh);
		end else begin
			if (sh > PW'(MAXV)) qsat = MAXV;
			else qsat = W'(sh);
		end
	endfunction

	// pick the operand of the cubic
	always_comb begin
		case (cmd.fsel)
			SEL_X0:  xsel = x0_q;
			SEL_X1:  xsel = x1_q;
			default: xsel = x2_q;
		endcase
	end

	// one shared signed multiplier: square, then saturated square times x
	always_comb begin
		case (cmd.op)
			OP_CUBE:  begin ma = qm;   mb = xsel; end
			OP_NUM_A: begin ma = x0_q; mb = f1_q; end
			OP_NUM_B: begin ma = x1_q; mb = f0_q; end
			default:  begin ma = xsel; mb = xsel; end
		endcase
		pr = PW'(ma) * PW'(mb);
	end

	assign qm   = qsat(prod_q);
	// the cube product sits in the product register during the finish step; qm saturates it
	assign fsum = (W+6)'(qm) - ((W+6)'(xsel) <<< 3) - (W+6)'(xsel) + ONE;
	assign fsat = (fsum > (W+6)'(MAXV)) ? MAXV :
		(fsum < (W+6)'(MINV)) ? MINV : W'(fsum);
	assign den  = (W+1)'(f1_q) - (W+1)'(f0_q);
	assign dmag = den[W] ? (W+1)'(-den) : den;
	assign rtry = {rem_q, nm_q[NW-1]} - {1'b0, d_q};

	// status toward the controller
	always_comb begin
		stat.f_equal   = (f0_q == f1_q);
		stat.den_zero  = (den == '0);
		stat.too_close = (TW'(dmag) < TW'(tol));
		stat.conv      = (TW'(f2_q[W-1] ? (W+1)'(-(W+1)'(f2_q)) : (W+1)'(f2_q))
				<= TW'(tol));
		stat.div_last  = (cnt_q == CW'(1));
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				OP_DIV_START: cnt_q <= CW'(NW);
				OP_DIV_STEP:  cnt_q <= cnt_q - CW'(1);
				default:      cnt_q <= cnt_q;
			endcase
		end
	end

	// register every step
	always_ff @(posedge clk) begin
		prod_q <= pr;
		case (cmd.op)
			OP_LOAD: begin
				x0_q <= x0_in;
				x1_q <= x1_in;
			end
			OP_FIN: begin
				case (cmd.fsel)
					SEL_X0:  f0_q <= fsat;
					SEL_X1:  f1_q <= fsat;
					default: f2_q <= fsat;
				endcase
			end
			// numerator assembly: x0*f1 then subtract x1*f0
			OP_NUM_B: num_q <= NW'(prod_q);
			OP_NUM_C: num_q <= num_q - NW'(prod_q);
			OP_DIV_START: begin
				rem_q <= '0;
				q_q   <= '0;
				d_q   <= dmag;
				nm_q  <= num_q[NW-1] ? NW'(-num_q) : num_q;
				neg_q <= num_q[NW-1] ^ den[W];
			end
			OP_DIV_STEP: begin
				rem_q <= rtry[W+1] ? (W+1)'({rem_q, nm_q[NW-1]}) : rtry[W:0];
				q_q   <= {q_q[NW-2:0], ~rtry[W+1]};
				nm_q  <= nm_q << 1;
			end
			OP_DIV_END: begin
				if (neg_q) x2_q <= (q_q > NW'({1'b1, {(W-1){1'b0}}})) ? MINV : W'(-q_q);
				else       x2_q <= (q_q > NW'(MAXV)) ? MAXV : W'(q_q);
			end
			OP_ADVANCE: begin
				x0_q <= x1_q;
				x1_q <= x2_q;
				f0_q <= f1_q;
				f1_q <= f2_q;
			end
			default: ;
		endcase
	end

	// report value
	always_comb begin
		if (status == ST_DIV_ERROR || status == ST_TOO_CLOSE) begin
			root = (-ONE < (W+6)'(MINV)) ? MINV : W'(-ONE);
		end else if (status == ST_CONVERGED) begin
			root = x2_q;
		end else begin
			root = x1_q;
		end
	end
endmodule
`default_nettype wire

[sv/secant_cubic_root_solver_core.sv]
// Top level: secant root solver for f(x) = x^3 - 9x + 1 in signed fixed point.
//
// Usage: raise start with first_guess and second_guess; the word is taken on
// an edge where start is high and busy is low. busy stays high while the
// solve runs. When it ends, done pulses for one cycle with root, iterations
// and status; the receiver takes it in that cycle and cannot stall.
// Sequence: a load step, then a cubic evaluation (square, cube, sum) for
// each starting value and a check step; each iteration then runs a loop
// check, 3 numerator build steps, 1 divider setup, 2*VALUE_WIDTH+1 = 65
// restoring divider steps at 32 bits, 1 quotient step, 3 cubic steps and
// 1 convergence check. The bit-serial divider dominates the solve time. One
// solve runs at a time; the next word is taken in the cycle after done.
// Configuration: cfg_we, cfg_addr (0 iteration_limit, 1 tolerance), cfg_data;
// write only while busy is low. Reset clears the controller and loads
// iteration_limit 20 and tolerance 7.
`default_nettype none
module secant_cubic_root_solver_core
	import scrs_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire signed [VALUE_WIDTH-1:0]  first_guess,
	input  wire signed [VALUE_WIDTH-1:0]  second_guess,
	input  wire                           cfg_we,
	input  wire [CFG_ADDR_W-1:0]          cfg_addr,
	input  wire [CFG_DATA_W-1:0]          cfg_data,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] root,
	output logic [LIMIT_W-1:0]            iterations,
	output logic [STATUS_W-1:0]           status
);
	logic [LIMIT_W-1:0] limit_q;
	logic [TOL_W-1:0]   tol_q;
	scrs_cmd_t          cmd;
	scrs_stat_t         stat;
	status_t            st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			tol_q   <= TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ITERATION_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				REG_TOLERANCE:       tol_q   <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	scrs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.limit      (limit_q),
		.stat       (stat),
		.busy       (busy),
		.done       (done),
		.cmd        (cmd),
		.status     (st),
		.iterations (iterations)
	);

	scrs_dp #(
		.FRAC_BITS   (FRAC_BITS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.x0_in  (first_guess),
		.x1_in  (second_guess),
		.tol    (tol_q),
		.status (st),
		.stat   (stat),
		.root   (root)
	);

	assign status = st;
endmodule
`default_nettype wire
